// File: rtl/tbdpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbdpc_pkg: shared types and constants of the two-button press classifier
// Counter sizing, configuration register indexes and reset values, the event
// codes and the configuration bundle used by the top level and button units.
// ----------------------------------------------------------------------------
package tbdpc_pkg;

    // Stable-time and held-time counter width (saturating)
    localparam int CNT_BITS = 16;
    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

    // Threshold fields are 16 bits wide; compares run at the wider of the two
    localparam int THR_BITS = 16;
    localparam int CMP_W    = (CNT_BITS > THR_BITS) ? CNT_BITS : THR_BITS;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE     = 3'd0,
        CFG_PRESSED_LV = 3'd1,
        CFG_DEBOUNCE   = 3'd2,
        CFG_LONG_MS    = 3'd3,
        CFG_FACTORY_MS = 3'd4
    } t_cfg_idx;

    localparam logic                RST_ENABLE     = 1'b1;
    localparam logic                RST_PRESSED_LV = 1'b0;
    localparam logic [7:0]          RST_DEBOUNCE   = 8'd50;
    localparam logic [THR_BITS-1:0] RST_LONG_MS    = 16'd1000;
    localparam logic [THR_BITS-1:0] RST_FACTORY_MS = 16'd10000;

    // Per-button event codes
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_SHORT   = 2'd1,
        EV_LONG    = 2'd2,
        EV_FACTORY = 2'd3
    } t_event;

    // Live configuration seen by both button units
    typedef struct packed {
        logic                enable;
        logic                pressed_level;
        logic [7:0]          debounce_ms;
        logic [THR_BITS-1:0] long_press_ms;
        logic [THR_BITS-1:0] factory_reset_ms;
    } t_cfg;

    // Saturating increment
    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_BITS'(1);
    endfunction

endpackage

// File: rtl/tbdpc_button.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbdpc_button: debounce and press timing for one button
// Holds the raw history, debounced level, stable and held counters and the
// reported flags. Computes this tick's event and the debounced pressed status
// in one pass; state advances only on an enabled accepted item.
// ----------------------------------------------------------------------------
module tbdpc_button (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,        // accepted item while enabled
    input  logic              i_raw,
    input  logic              i_factory_en,  // tie high for the mode button
    input  tbdpc_pkg::t_cfg   i_cfg,
    output tbdpc_pkg::t_event o_event,
    output logic              o_pressed      // status after this item
);
    import tbdpc_pkg::*;

    logic                r_prev_raw, n_prev_raw;
    logic                r_level,    n_level;
    logic [CNT_BITS-1:0] r_stable,   n_stable;
    logic [CNT_BITS-1:0] r_held,     n_held;
    logic                r_long,     n_long;
    logic                r_fac,      n_fac;

    logic                was_pressed;
    logic                now_pressed;
    logic                edge_det;
    logic                lvl_new;
    logic [CNT_BITS-1:0] held_inc;
    logic [CNT_BITS-1:0] stable_new;
    logic [CMP_W-1:0]    held_inc_w;
    logic [CMP_W-1:0]    held_w;
    logic [CMP_W-1:0]    long_w;
    logic [CMP_W-1:0]    fac_w;
    logic                fac_seen;
    t_event              ev;

    // Tick update, in the order: held count, stable count, edge, flags, checks
    always_comb begin
        was_pressed = (r_level == i_cfg.pressed_level);
        held_inc    = was_pressed ? sat_inc(r_held) : r_held;
        stable_new  = (i_raw != r_prev_raw) ? '0 : sat_inc(r_stable);
        edge_det    = (CMP_W'(stable_new) > CMP_W'(i_cfg.debounce_ms))
                      && (i_raw != r_level);
        lvl_new     = edge_det ? i_raw : r_level;
        now_pressed = (lvl_new == i_cfg.pressed_level);
        held_inc_w  = CMP_W'(held_inc);
        long_w      = CMP_W'(i_cfg.long_press_ms);
        fac_w       = CMP_W'(i_cfg.factory_reset_ms);
        fac_seen    = i_factory_en && r_fac;

        ev          = EV_NONE;
        n_held      = held_inc;
        n_long      = r_long;
        n_fac       = r_fac;

        // Release edge may give a short press; any edge restarts the press
        if (edge_det) begin
            if (!now_pressed && !r_long && !fac_seen && (held_inc_w < long_w)) begin
                ev = EV_SHORT;
            end
            n_held = '0;
            n_long = 1'b0;
            n_fac  = 1'b0;
        end

        held_w = CMP_W'(n_held);

        // Factory reset has priority; a due long press waits one tick
        if (now_pressed) begin
            if (i_factory_en && !n_fac && (held_w >= fac_w)) begin
                n_fac = 1'b1;
                ev    = EV_FACTORY;
            end else if (!n_long && (held_w >= long_w)) begin
                n_long = 1'b1;
                ev     = EV_LONG;
            end
        end

        n_prev_raw = i_raw;
        n_level    = lvl_new;
        n_stable   = stable_new;
    end

    assign o_event   = i_step ? ev : EV_NONE;
    assign o_pressed = (i_step ? lvl_new : r_level) == i_cfg.pressed_level;

    // Button state; released level (under reset polarity) after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw <= ~RST_PRESSED_LV;
            r_level    <= ~RST_PRESSED_LV;
            r_stable   <= '0;
            r_held     <= '0;
            r_long     <= 1'b0;
            r_fac      <= 1'b0;
        end else if (i_step) begin
            r_prev_raw <= n_prev_raw;
            r_level    <= n_level;
            r_stable   <= n_stable;
            r_held     <= n_held;
            r_long     <= n_long;
            r_fac      <= n_fac;
        end
    end

    // A level change only follows a run of stable ticks past the debounce time
    a_level_change_debounced: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (n_level != r_level)) |-> (CMP_W'(n_stable) > CMP_W'(i_cfg.debounce_ms))
    ) else $error("debounced level changed before the stable time elapsed");

    // Every edge restarts press timing
    a_edge_clears_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_step && edge_det) |=> (r_held == '0)
    ) else $error("held counter not cleared on a debounced edge");

    // Long events set their flag
    a_long_sets_flag: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_event == EV_LONG) |=> r_long
    ) else $error("long press reported without setting its flag");

endmodule

// File: rtl/two_button_debounce_press_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_button_debounce_press_classifier: debounce and press classifier
// Each item is one 1 ms tick with the raw levels of the mode and set buttons.
// Each tick produces one result: an event per button and the debounced
// pressed status of both.
// ----------------------------------------------------------------------------
// Usage: one result per accepted tick item, registered and available in the
// cycle after the item is accepted. o_in_ready is high whenever the result
// register is empty or is being taken in the same cycle, so the block takes
// one item per clock while results are taken; the sustained rate is set by
// the single result register. Both buttons are updated in parallel by short
// counter and compare logic. Configuration writes are always accepted
// (o_cfg_ready is tied high) and should be made only when no result is
// pending. Unknown register indexes are ignored.
// ----------------------------------------------------------------------------
module two_button_debounce_press_classifier (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tick items
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_mode_raw,
    input  logic                                 i_set_raw,
    // results
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [1:0]                           o_mode_event,
    output logic [1:0]                           o_set_event,
    output logic                                 o_mode_pressed,
    output logic                                 o_set_pressed,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tbdpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tbdpc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tbdpc_pkg::*;

    t_cfg   r_cfg;
    logic   r_out_valid;
    t_event r_mode_event;
    t_event r_set_event;
    logic   r_mode_pressed;
    logic   r_set_pressed;

    logic   in_acc;
    logic   step;
    t_event mode_ev;
    t_event set_ev;
    logic   mode_pr;
    logic   set_pr;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign step        = in_acc && r_cfg.enable;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable           <= RST_ENABLE;
            r_cfg.pressed_level    <= RST_PRESSED_LV;
            r_cfg.debounce_ms      <= RST_DEBOUNCE;
            r_cfg.long_press_ms    <= RST_LONG_MS;
            r_cfg.factory_reset_ms <= RST_FACTORY_MS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLE:     r_cfg.enable           <= i_cfg_data[0];
                CFG_PRESSED_LV: r_cfg.pressed_level    <= i_cfg_data[0];
                CFG_DEBOUNCE:   r_cfg.debounce_ms      <= i_cfg_data[7:0];
                CFG_LONG_MS:    r_cfg.long_press_ms    <= i_cfg_data[THR_BITS-1:0];
                CFG_FACTORY_MS: r_cfg.factory_reset_ms <= i_cfg_data[THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Button units; only the mode button reports factory reset
    tbdpc_button u_mode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_raw        (i_mode_raw),
        .i_factory_en (1'b1),
        .i_cfg        (r_cfg),
        .o_event      (mode_ev),
        .o_pressed    (mode_pr)
    );

    tbdpc_button u_set (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_raw        (i_set_raw),
        .i_factory_en (1'b0),
        .i_cfg        (r_cfg),
        .o_event      (set_ev),
        .o_pressed    (set_pr)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode_event   <= mode_ev;
            r_set_event    <= set_ev;
            r_mode_pressed <= mode_pr;
            r_set_pressed  <= set_pr;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mode_event   = r_mode_event;
    assign o_set_event    = r_set_event;
    assign o_mode_pressed = r_mode_pressed;
    assign o_set_pressed  = r_set_pressed;

    // A disabled tick yields no events
    a_disabled_quiet: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_cfg.enable) |=> (o_mode_event == EV_NONE && o_set_event == EV_NONE)
    ) else $error("event reported on a disabled tick");

    // The set button never reports factory reset
    a_set_no_factory: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_set_event != EV_FACTORY)
    ) else $error("factory reset reported on the set button");

    // A short press comes with a release, long/factory while held
    a_mode_short_released: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_mode_event == EV_SHORT) |-> !o_mode_pressed
    ) else $error("mode short press reported while still pressed");

    a_mode_hold_pressed: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_mode_event == EV_LONG || o_mode_event == EV_FACTORY))
            |-> o_mode_pressed
    ) else $error("mode long or factory event reported while released");

endmodule

// File: tb/two_button_debounce_press_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_button_debounce_press_classifier_tb: self-checking bench for the
// two-button debounce and press classifier
// Tick items go in over a valid/ready channel and one result per tick comes
// back. A behavioral copy of the debounce and press timing predicts every
// result, and each result is compared field by field. A short directed table
// covers reset, thresholds of zero, factory and long due together, polarity
// change, disable and the register extremes. Random phases of bouncing
// presses follow, then an unbroken hold at the longest debounce time with
// long press and factory reset due together.
// ----------------------------------------------------------------------------
module two_button_debounce_press_classifier_tb;
    import tbdpc_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_TICKS  = 700;
    localparam int UNUSED_IDX_LO = int'(CFG_FACTORY_MS) + 1;
    localparam int MODE_HOLD     = 300;
    localparam int SET_HOLD      = 290;
    localparam int RELEASE_TICKS = 300;
    localparam int HOLD_THR      = 20;

    typedef struct packed {
        t_event mode_ev;
        t_event set_ev;
        logic   mode_pr;
        logic   set_pr;
    } t_tick_result;

    typedef enum logic {ROW_TICK, ROW_SETUP} t_row_kind;

    typedef struct {
        t_row_kind    kind;
        logic         m;
        logic         s;
        bit           typed;
        t_tick_result res;
        logic         en;
        logic         pl;
        logic [7:0]   deb;
        logic [15:0]  lng;
        logic [15:0]  fac;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic i_mode_raw;
    logic i_set_raw;
    logic o_out_valid;
    logic i_out_ready;
    logic [1:0] o_mode_event;
    logic [1:0] o_set_event;
    logic o_mode_pressed;
    logic o_set_pressed;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    two_button_debounce_press_classifier i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode_raw     (i_mode_raw),
        .i_set_raw      (i_set_raw),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_mode_event   (o_mode_event),
        .o_set_event    (o_set_event),
        .o_mode_pressed (o_mode_pressed),
        .o_set_pressed  (o_set_pressed),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the configuration
    logic        cfg_en;
    logic        cfg_pl;
    logic [7:0]  cfg_deb;
    logic [15:0] cfg_long;
    logic [15:0] cfg_fac;

    // Predictor copy of the per-button state (index 0 mode, 1 set)
    logic                btn_prev [2];
    logic                btn_level [2];
    logic [CNT_BITS-1:0] stable_cnt [2];
    logic [CNT_BITS-1:0] held_cnt [2];
    logic                long_flag [2];
    logic                factory_flag;

    t_tick_result pending_results [$];
    t_dir_row     dir_rows [$];

    // Random press generator state
    logic gen_level [2];
    int   gen_left [2];

    bit idle_on = 1'b1;
    int mismatch_count = 0;
    int results_checked = 0;
    int ticks_sent = 0;
    int n_short = 0;
    int n_long = 0;
    int n_factory = 0;
    t_tick_result want;

    function automatic logic [CNT_BITS-1:0] count_up(input logic [CNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic void reset_model();
        int b;
        cfg_en   = RST_ENABLE;
        cfg_pl   = RST_PRESSED_LV;
        cfg_deb  = RST_DEBOUNCE;
        cfg_long = RST_LONG_MS;
        cfg_fac  = RST_FACTORY_MS;
        for (b = 0; b < 2; b++) begin
            btn_prev[b]   = ~RST_PRESSED_LV;
            btn_level[b]  = ~RST_PRESSED_LV;
            stable_cnt[b] = '0;
            held_cnt[b]   = '0;
            long_flag[b]  = 1'b0;
            gen_level[b]  = ~RST_PRESSED_LV;
            gen_left[b]   = 0;
        end
        factory_flag = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ENABLE:     cfg_en   = data[0];
            CFG_PRESSED_LV: cfg_pl   = data[0];
            CFG_DEBOUNCE:   cfg_deb  = data[7:0];
            CFG_LONG_MS:    cfg_long = data[15:0];
            CFG_FACTORY_MS: cfg_fac  = data[15:0];
            default: ;
        endcase
    endfunction

    // One tick of one button: debounce, hold timing and event choice
    function automatic t_event step_button(input int b, input logic raw);
        logic   was_pr;
        logic   now_pr;
        logic   flip;
        t_event ev;
        ev     = EV_NONE;
        flip   = 1'b0;
        was_pr = (btn_level[b] == cfg_pl);
        if (was_pr)
            held_cnt[b] = count_up(held_cnt[b]);
        if (raw != btn_prev[b])
            stable_cnt[b] = '0;
        else
            stable_cnt[b] = count_up(stable_cnt[b]);
        btn_prev[b] = raw;
        if (stable_cnt[b] > cfg_deb && raw != btn_level[b]) begin
            btn_level[b] = raw;
            flip = 1'b1;
        end
        now_pr = (btn_level[b] == cfg_pl);
        // a release with nothing reported yet and a short hold is a short press
        if (flip) begin
            if (!now_pr && !long_flag[b] && !(b == 0 && factory_flag) &&
                    held_cnt[b] < cfg_long)
                ev = EV_SHORT;
            held_cnt[b]  = '0;
            long_flag[b] = 1'b0;
            if (b == 0)
                factory_flag = 1'b0;
        end
        // factory reset wins over long press; long waits one tick
        if (now_pr) begin
            if (b == 0 && !factory_flag && held_cnt[b] >= cfg_fac) begin
                factory_flag = 1'b1;
                ev = EV_FACTORY;
            end else if (!long_flag[b] && held_cnt[b] >= cfg_long) begin
                long_flag[b] = 1'b1;
                ev = EV_LONG;
            end
        end
        return ev;
    endfunction

    function automatic t_tick_result classify_tick(input logic m, input logic s);
        t_tick_result r;
        r.mode_ev = EV_NONE;
        r.set_ev  = EV_NONE;
        if (cfg_en) begin
            r.mode_ev = step_button(0, m);
            r.set_ev  = step_button(1, s);
        end
        r.mode_pr = (btn_level[0] == cfg_pl);
        r.set_pr  = (btn_level[1] == cfg_pl);
        return r;
    endfunction

    // Bouncy press/release pattern scaled to the current thresholds
    function automatic logic next_level(input int b);
        int r;
        int d;
        int span_l;
        int span_f;
        d      = cfg_deb;
        span_l = (cfg_long > 200) ? 200 : cfg_long;
        span_f = (cfg_fac > 300) ? 300 : cfg_fac;
        if (gen_left[b] == 0) begin
            gen_level[b] = ~gen_level[b];
            r = $urandom_range(0, 9);
            if (r < 2)
                gen_left[b] = $urandom_range(1, d + 1);
            else if (r < 6)
                gen_left[b] = $urandom_range(d + 1, d + span_l + 2);
            else if (r < 9)
                gen_left[b] = $urandom_range(d + span_l, d + span_f + 4);
            else
                gen_left[b] = $urandom_range(1, 4);
        end
        gen_left[b]--;
        return ($urandom_range(0, 99) < 8) ? ~gen_level[b] : gen_level[b];
    endfunction

    function automatic t_dir_row tick_row(input logic m, input logic s);
        t_dir_row row;
        row = '{kind: ROW_TICK, m: m, s: s, typed: 1'b0, res: '0,
                en: 1'b0, pl: 1'b0, deb: '0, lng: '0, fac: '0};
        return row;
    endfunction

    function automatic t_dir_row checked_row(input logic m, input logic s,
                                             input t_tick_result res);
        t_dir_row row;
        row       = tick_row(m, s);
        row.typed = 1'b1;
        row.res   = res;
        return row;
    endfunction

    function automatic t_dir_row setup_row(input logic en, input logic pl,
                                           input logic [7:0] deb,
                                           input logic [15:0] lng,
                                           input logic [15:0] fac);
        t_dir_row row;
        row = '{kind: ROW_SETUP, m: 1'b0, s: 1'b0, typed: 1'b0, res: '0,
                en: en, pl: pl, deb: deb, lng: lng, fac: fac};
        return row;
    endfunction

    // Present one tick item and hold it until taken; valid stays high after
    task automatic send_tick(input logic m, input logic s, input bit typed,
                             input t_tick_result typed_res);
        int gap;
        t_tick_result r;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode_raw <= m;
        i_set_raw  <= s;
        do @(posedge i_clk); while (!o_in_ready);
        r = classify_tick(m, s);
        pending_results.push_back(typed ? typed_res : r);
        ticks_sent++;
    endtask

    // Write all registers plus one unmapped index once the block is idle
    task automatic write_regs(input logic en, input logic pl, input logic [7:0] deb,
                              input logic [15:0] lng, input logic [15:0] fac);
        logic [CFG_DATA_W-1:0] vals [5];
        t_cfg_idx              regs [5];
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        int i;
        regs    = '{CFG_ENABLE, CFG_PRESSED_LV, CFG_DEBOUNCE, CFG_LONG_MS, CFG_FACTORY_MS};
        // upper bits are junk on the narrow registers
        vals[0] = {15'($urandom), en};
        vals[1] = {15'($urandom), pl};
        vals[2] = {8'($urandom), deb};
        vals[3] = lng;
        vals[4] = fac;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        for (i = 0; i <= 5; i++) begin
            if (i < 5) begin
                idx  = regs[i];
                data = vals[i];
            end else begin
                idx  = CFG_IDX_W'($urandom_range(UNUSED_IDX_LO, (1 << CFG_IDX_W) - 1));
                data = CFG_DATA_W'($urandom);
            end
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= data;
            do @(posedge i_clk); while (!o_cfg_ready);
            apply_reg(idx, data);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_threshold(input int typical_max);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'd0;
        else if (r == 1)
            return 16'hFFFF;
        else if (r == 2)
            return 16'($urandom);
        return 16'($urandom_range(1, typical_max));
    endfunction

    // Result receiver with random stall bursts
    initial begin
        i_out_ready <= 1'b1;
        @(posedge i_clk);
        forever begin
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            if (idle_on && $urandom_range(0, 1) == 1) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $error("result with no tick pending: mode_event %0d set_event %0d",
                       o_mode_event, o_set_event);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_mode_event !== want.mode_ev) begin
                    mismatch_count++;
                    $error("mode_event: expected %0d, got %0d", want.mode_ev, o_mode_event);
                end
                if (o_set_event !== want.set_ev) begin
                    mismatch_count++;
                    $error("set_event: expected %0d, got %0d", want.set_ev, o_set_event);
                end
                if (o_mode_pressed !== want.mode_pr) begin
                    mismatch_count++;
                    $error("mode_pressed: expected %0d, got %0d", want.mode_pr,
                           o_mode_pressed);
                end
                if (o_set_pressed !== want.set_pr) begin
                    mismatch_count++;
                    $error("set_pressed: expected %0d, got %0d", want.set_pr,
                           o_set_pressed);
                end
                if (want.mode_ev == EV_SHORT) n_short++;
                if (want.set_ev == EV_SHORT) n_short++;
                if (want.mode_ev == EV_LONG) n_long++;
                if (want.set_ev == EV_LONG) n_long++;
                if (want.mode_ev == EV_FACTORY) n_factory++;
            end
        end
    end

    // Timeout
    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("two_button_debounce_press_classifier_tb: done, errors");
        $finish;
    end

    // Stimulus
    initial begin
        int i;
        int n;
        int random_ticks;
        int waited;
        bit noise;
        logic pl;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_mode_raw  <= 1'b0;
        i_set_raw   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_ENABLE;
        i_cfg_data  <= '0;
        reset_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        // released level out of reset: nothing happens
        dir_rows.push_back(checked_row(1'b1, 1'b1, '{EV_NONE, EV_NONE, 1'b0, 1'b0}));
        // both held through long, then mode through factory reset
        dir_rows.push_back(setup_row(1'b1, 1'b0, 8'd0, 16'd3, 16'd5));
        for (i = 0; i < 6; i++) dir_rows.push_back(tick_row(1'b0, 1'b0));
        dir_rows.push_back(tick_row(1'b1, 1'b1));
        dir_rows.push_back(tick_row(1'b1, 1'b1));
        // short press on set
        dir_rows.push_back(tick_row(1'b1, 1'b0));
        dir_rows.push_back(tick_row(1'b1, 1'b0));
        dir_rows.push_back(tick_row(1'b1, 1'b1));
        dir_rows.push_back(tick_row(1'b1, 1'b1));
        // zero thresholds: factory on the press tick, long one tick later
        dir_rows.push_back(setup_row(1'b1, 1'b0, 8'd0, 16'd0, 16'd0));
        dir_rows.push_back(tick_row(1'b0, 1'b1));
        dir_rows.push_back(checked_row(1'b0, 1'b1, '{EV_FACTORY, EV_NONE, 1'b1, 1'b0}));
        dir_rows.push_back(checked_row(1'b0, 1'b1, '{EV_LONG, EV_NONE, 1'b1, 1'b0}));
        // polarity flipped mid-press
        dir_rows.push_back(setup_row(1'b1, 1'b1, 8'd0, 16'd0, 16'd0));
        dir_rows.push_back(tick_row(1'b0, 1'b1));
        // disabled: ticks ignored
        dir_rows.push_back(setup_row(1'b0, 1'b1, 8'd0, 16'd3, 16'd5));
        dir_rows.push_back(tick_row(1'b1, 1'b0));
        dir_rows.push_back(tick_row(1'b1, 1'b0));
        // register extremes
        dir_rows.push_back(setup_row(1'b1, 1'b0, 8'd255, 16'd65534, 16'd65534));
        dir_rows.push_back(tick_row(1'b0, 1'b0));
        dir_rows.push_back(tick_row(1'b0, 1'b0));

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_SETUP)
                write_regs(dir_rows[k].en, dir_rows[k].pl, dir_rows[k].deb,
                           dir_rows[k].lng, dir_rows[k].fac);
            else
                send_tick(dir_rows[k].m, dir_rows[k].s, dir_rows[k].typed,
                          dir_rows[k].res);
        end

        // random phases of bouncing presses and plain noise
        random_ticks = 0;
        while (random_ticks < RANDOM_TICKS) begin
            write_regs($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)),
                       ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)),
                       pick_threshold(30), pick_threshold(60));
            idle_on = ($urandom_range(0, 3) != 0);
            noise   = ($urandom_range(0, 4) == 0);
            n = $urandom_range(100, 170);
            for (i = 0; i < n; i++) begin
                if (noise)
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'b0, '0);
                else
                    send_tick(next_level(0), next_level(1), 1'b0, '0);
                if (cfg_en)
                    random_ticks++;
            end
        end

        // unbroken hold, no idling: longest debounce, factory and long due
        // together on mode, long press on set
        idle_on = 1'b0;
        pl = 1'($urandom_range(0, 1));
        write_regs(1'b1, pl, 8'd255, 16'(HOLD_THR), 16'(HOLD_THR));
        for (i = 0; i < MODE_HOLD; i++)
            send_tick(pl, (i < SET_HOLD) ? pl : ~pl, 1'b0, '0);
        for (i = 0; i < RELEASE_TICKS; i++)
            send_tick(~pl, ~pl, 1'b0, '0);
        i_in_valid <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            mismatch_count += pending_results.size();
            $error("%0d results never arrived", pending_results.size());
        end

        $display("covered %0d ticks, %0d results checked", ticks_sent, results_checked);
        $display("events seen: %0d short, %0d long, %0d factory reset",
                 n_short, n_long, n_factory);
        if (mismatch_count == 0)
            $display("two_button_debounce_press_classifier_tb: done, clean");
        else
            $display("two_button_debounce_press_classifier_tb: done, errors");
        $finish;
    end

endmodule
